// ===== hw/rtl/asmk_pkg.sv =====
// shared types and codes for the approximate string match core
package asmk_pkg;

	localparam int CELL_W = 7;
	localparam logic [CELL_W-1:0] CELL_MAX = 7'd127;

	localparam logic [1:0] MODE_LOAD    = 2'd0;
	localparam logic [1:0] MODE_RESTART = 2'd1;
	localparam logic [1:0] MODE_TEXT    = 2'd2;

	localparam logic REG_PATTERN_LENGTH = 1'b0;
	localparam logic REG_MAX_DISTANCE   = 1'b1;

	typedef struct packed {
		logic              v;
		logic [7:0]        ch;
		logic [CELL_W-1:0] new_val;
		logic [CELL_W-1:0] old_val;
	} asmk_link_t;

	function automatic logic [CELL_W-1:0] sat_inc(input logic [CELL_W-1:0] v);
		sat_inc = (v == CELL_MAX) ? CELL_MAX : v + 7'd1;
	endfunction

endpackage

// ===== hw/rtl/asmk_cell.sv =====
// one pattern row of the edit distance column, passes the wavefront on
module asmk_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  asmk_pkg::asmk_link_t     link_in,
	input  logic                     active,
	input  logic                     restart,
	input  logic [asmk_pkg::CELL_W-1:0] init_val,
	input  logic                     load_en,
	input  logic [7:0]               load_char,
	output asmk_pkg::asmk_link_t     link_out
);

	logic [7:0]                    pat_q;
	logic [asmk_pkg::CELL_W-1:0]   col_q;
	logic                          v_q;
	logic [7:0]                    ch_q;
	logic [asmk_pkg::CELL_W-1:0]   new_q;
	logic [asmk_pkg::CELL_W-1:0]   old_q;
	logic [asmk_pkg::CELL_W-1:0]   up_inc;
	logic [asmk_pkg::CELL_W-1:0]   here_inc;
	logic [asmk_pkg::CELL_W-1:0]   diag;
	logic [asmk_pkg::CELL_W-1:0]   best_a;
	logic [asmk_pkg::CELL_W-1:0]   best;

	always_comb begin
		up_inc   = asmk_pkg::sat_inc(link_in.new_val);
		here_inc = asmk_pkg::sat_inc(col_q);
		diag     = (pat_q == link_in.ch) ? link_in.old_val : asmk_pkg::sat_inc(link_in.old_val);
		best_a   = (here_inc < up_inc) ? here_inc : up_inc;
		best     = (diag < best_a) ? diag : best_a;
	end

	always_ff @(posedge clk) begin
		if (load_en) begin
			pat_q <= load_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= init_val;
			v_q   <= 1'b0;
		end else begin
			v_q <= link_in.v;
			if (restart) begin
				col_q <= init_val;
			end else if (link_in.v && active) begin
				col_q <= best;
			end
		end
	end

	// inactive rows pass the upper value on unchanged
	always_ff @(posedge clk) begin
		ch_q  <= link_in.ch;
		new_q <= active ? best : link_in.new_val;
		old_q <= col_q;
	end

	assign link_out = '{v: v_q, ch: ch_q, new_val: new_q, old_val: old_q};

endmodule

// ===== hw/rtl/approx_string_match_k_diff_core.sv =====
// Approximate string matcher (k differences, edit distance column per text item).
// A chain of MAX_PATTERN cells, one per pattern row, holds the column; a text
// item enters at row 1 and the wavefront moves one cell per cycle to the end of
// the chain, and its result passes through a one-entry result buffer into the
// output register. The next item is taken once the chain is free and the result
// buffer has drained to the output register. Rows above pattern_length keep
// their values and only forward the row value to the chain end.
module approx_string_match_k_diff_core #(
	parameter int MAX_PATTERN = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [7:0]  char_value,
	input  logic [5:0]  pattern_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [6:0]  distance,
	output logic        is_match,
	output logic [31:0] end_position,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_data
);

	asmk_pkg::asmk_link_t link [0:MAX_PATTERN];

	logic        in_acc;
	logic        text_acc;
	logic        restart;
	logic        load;
	logic        done;
	logic        busy_q;
	logic [31:0] pos_q;
	logic [31:0] tok_pos_q;
	logic [6:0]  pl_q;
	logic [6:0]  k_q;
	logic        pend_v_q;
	logic [6:0]  pend_dist_q;
	logic        pend_match_q;
	logic [31:0] pend_pos_q;
	logic        out_v_q;
	logic [6:0]  out_dist_q;
	logic        out_match_q;
	logic [31:0] out_pos_q;
	logic        move;

	assign in_ready  = !busy_q && !pend_v_q;
	assign in_acc    = in_valid && in_ready;
	assign text_acc  = in_acc && (mode == asmk_pkg::MODE_TEXT);
	assign restart   = in_acc && (mode == asmk_pkg::MODE_RESTART);
	assign load      = in_acc && (mode == asmk_pkg::MODE_LOAD);
	assign cfg_ready = 1'b1;
	assign done      = link[MAX_PATTERN].v;
	assign move      = pend_v_q && (!out_v_q || out_ready);

	assign link[0] = '{v: text_acc, ch: char_value, new_val: '0, old_val: '0};

	for (genvar k = 1; k <= MAX_PATTERN; k++) begin : g_cell
		localparam logic [6:0] INIT = (k > 127) ? 7'd127 : 7'(k);
		asmk_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.link_in  (link[k-1]),
			.active   (k <= int'(pl_q)),
			.restart  (restart),
			.init_val (INIT),
			.load_en  (load && (int'(pattern_index) == k - 1)),
			.load_char(char_value),
			.link_out (link[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pl_q <= 7'd1;
			k_q  <= 7'd0;
		end else if (cfg_valid) begin
			case (cfg_index)
				asmk_pkg::REG_PATTERN_LENGTH: pl_q <= cfg_data;
				asmk_pkg::REG_MAX_DISTANCE:   k_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			pos_q    <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (text_acc) begin
				busy_q <= 1'b1;
				pos_q  <= pos_q + 32'd1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
			if (restart) begin
				pos_q <= '0;
			end
			if (done) begin
				pend_v_q <= 1'b1;
			end else if (move) begin
				pend_v_q <= 1'b0;
			end
			if (move) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (text_acc) begin
			tok_pos_q <= pos_q;
		end
		if (done) begin
			pend_dist_q  <= link[MAX_PATTERN].new_val;
			pend_match_q <= (link[MAX_PATTERN].new_val <= k_q);
			pend_pos_q   <= tok_pos_q;
		end
		if (move) begin
			out_dist_q  <= pend_dist_q;
			out_match_q <= pend_match_q;
			out_pos_q   <= pend_pos_q;
		end
	end

	assign out_valid    = out_v_q;
	assign distance     = out_dist_q;
	assign is_match     = out_match_q;
	assign end_position = out_pos_q;

endmodule

// ===== hw/rtl/asmk_checker.sv =====
// port checks for the approximate string match core and their binding
module asmk_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  mode,
	input logic        out_valid,
	input logic        out_ready,
	input logic [6:0]  distance,
	input logic        is_match,
	input logic [31:0] end_position,
	input logic        cfg_ready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(distance) && $stable(end_position))
		else $error("result item changed while stalled");

	a_zero_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (distance == 7'd0) |-> is_match)
		else $error("exact match not flagged");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("config port not ready");

	a_text_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (mode == asmk_pkg::MODE_TEXT) |=> !in_ready)
		else $error("text item taken while chain busy");

endmodule

bind approx_string_match_k_diff_core asmk_checker u_asmk_checker (.*);

// ===== tb/asmk_distance_checker.sv =====
// distance checker: tracks the edit-distance column and compares every result item
module asmk_distance_checker #(
	parameter int ROWS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [7:0]  char_value,
	input  logic [5:0]  pattern_index,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [6:0]  distance,
	input  logic        is_match,
	input  logic [31:0] end_position,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_data,
	output int          mismatches,
	output int          outstanding,
	output int          checked,
	output int          match_total
);

	typedef struct packed {
		logic [6:0]  dist_val;
		logic        hit;
		logic [31:0] pos;
	} score_t;

	logic [7:0]  pattern [ROWS];
	logic [6:0]  column [ROWS+1];
	logic [31:0] text_pos;
	logic [6:0]  len_reg;
	logic [6:0]  k_reg;
	score_t      distances_due [$];
	score_t      want;
	int          err_count;
	int          seen_count;
	int          hit_count;

	function automatic score_t advance_column(input logic [7:0] ch);
		score_t res;
		int     rows;
		int     above_old;
		int     here_old;
		int     best;
		int     cand;
		rows = (len_reg > ROWS) ? ROWS : int'(len_reg);
		above_old = column[0];
		column[0] = '0;
		for (int r = 1; r <= rows; r++) begin
			here_old = column[r];
			best = column[r-1] + 1;
			cand = here_old + 1;
			if (cand < best)
				best = cand;
			cand = above_old + ((pattern[r-1] == ch) ? 0 : 1);
			if (cand < best)
				best = cand;
			if (best > 127)
				best = 127;
			column[r] = best[6:0];
			above_old = here_old;
		end
		res.dist_val = column[rows];
		res.hit      = (column[rows] <= k_reg);
		res.pos      = text_pos;
		text_pos = text_pos + 32'd1;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ROWS; r++)
				pattern[r] = '0;
			for (int r = 0; r <= ROWS; r++)
				column[r] = (r > 127) ? 7'd127 : 7'(r);
			text_pos = '0;
			len_reg = 7'd1;
			k_reg = 7'd0;
			distances_due.delete();
			outstanding <= 0;
			mismatches <= err_count;
		end else begin
			if (out_valid && out_ready) begin
				if (distances_due.size() == 0) begin
					err_count++;
					if (err_count <= 10)
						$display("unexpected result item: dist %0d match %0b pos %0d",
							distance, is_match, end_position);
				end else begin
					want = distances_due.pop_front();
					seen_count++;
					if (is_match === 1'b1)
						hit_count++;
					if (distance !== want.dist_val || is_match !== want.hit ||
						end_position !== want.pos) begin
						err_count++;
						if (err_count <= 10)
							$display("result %0d: expected %0d/%0b/%0d, got %0d/%0b/%0d",
								seen_count, want.dist_val, want.hit, want.pos,
								distance, is_match, end_position);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					asmk_pkg::REG_PATTERN_LENGTH: len_reg = cfg_data;
					asmk_pkg::REG_MAX_DISTANCE:   k_reg = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				case (mode)
					asmk_pkg::MODE_LOAD: pattern[pattern_index] = char_value;
					asmk_pkg::MODE_RESTART: begin
						for (int r = 0; r <= ROWS; r++)
							column[r] = (r > 127) ? 7'd127 : 7'(r);
						text_pos = '0;
					end
					asmk_pkg::MODE_TEXT: distances_due.push_back(advance_column(char_value));
					default: ;
				endcase
			end
			mismatches <= err_count;
			outstanding <= distances_due.size();
			checked <= seen_count;
			match_total <= hit_count;
		end
	end

endmodule

// ===== tb/tb_approx_string_match_k_diff_core.sv =====
// testbench top for the approximate string match core: stimulus, idling and verdict
module tb_approx_string_match_k_diff_core;

	localparam int         ROWS         = 64;
	localparam int         DRAIN_CYCLES = ROWS + 16;
	localparam int         ITEM_GOAL    = 1850;
	localparam int         PHASE_ITEMS  = 150;
	localparam logic [1:0] MODE_UNUSED  = 2'd3;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  mode = asmk_pkg::MODE_RESTART;
	logic [7:0]  char_value = '0;
	logic [5:0]  pattern_index = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [6:0]  distance;
	logic        is_match;
	logic [31:0] end_position;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = asmk_pkg::REG_PATTERN_LENGTH;
	logic [6:0]  cfg_data = '0;

	int          mismatches;
	int          outstanding;
	int          checked;
	int          match_total;

	int          send_idle = 30;
	int          recv_idle = 45;
	int          sent = 0;
	int          settings_used = 0;
	int          rows_in_use = 1;
	bit          wide_alpha = 1'b0;
	logic [63:0] loaded = '0;
	logic [7:0]  pat_copy [ROWS];

	approx_string_match_k_diff_core #(.MAX_PATTERN(ROWS)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .char_value(char_value), .pattern_index(pattern_index),
		.out_valid(out_valid), .out_ready(out_ready),
		.distance(distance), .is_match(is_match), .end_position(end_position),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	asmk_distance_checker #(.ROWS(ROWS)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .char_value(char_value), .pattern_index(pattern_index),
		.out_valid(out_valid), .out_ready(out_ready),
		.distance(distance), .is_match(is_match), .end_position(end_position),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatches(mismatches), .outstanding(outstanding),
		.checked(checked), .match_total(match_total)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#(8 * 2_000_000);
		$display("Mismatches found");
		$finish;
	end

	initial begin
		forever begin
			@(posedge clk);
			out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	function automatic logic [7:0] pick_char();
		return wide_alpha ? 8'($urandom_range(255)) : 8'(8'h61 + $urandom_range(3));
	endfunction

	task automatic push_item(input logic [1:0] md, input logic [7:0] ch, input logic [5:0] ix);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= md;
		char_value <= ch;
		pattern_index <= ix;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (md == asmk_pkg::MODE_LOAD) begin
			loaded[ix] = 1'b1;
			pat_copy[ix] = ch;
		end
		if (md != MODE_UNUSED)
			sent++;
	endtask

	task automatic push_text(input logic [7:0] ch);
		push_item(asmk_pkg::MODE_TEXT, ch, 6'($urandom));
	endtask

	task automatic push_restart();
		push_item(asmk_pkg::MODE_RESTART, 8'($urandom), 6'($urandom));
	endtask

	// wait for every result item, then let loads and restarts finish too
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_regs(input logic [6:0] len, input logic [6:0] k);
		cfg_valid <= 1'b1;
		cfg_index <= asmk_pkg::REG_PATTERN_LENGTH;
		cfg_data <= len;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_index <= asmk_pkg::REG_MAX_DISTANCE;
		cfg_data <= k;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		rows_in_use = (len > ROWS) ? ROWS : int'(len);
		settings_used++;
	endtask

	task automatic load_pattern(input bit fresh);
		for (int i = 0; i < rows_in_use; i++)
			if (fresh || !loaded[i])
				push_item(asmk_pkg::MODE_LOAD, pick_char(), 6'(i));
	endtask

	// pattern copy with occasional substitution, deletion and insertion
	task automatic copy_pattern();
		int r;
		for (int i = 0; i < rows_in_use; i++) begin
			r = $urandom_range(19);
			if (r == 0)
				push_text(pick_char());
			else if (r == 2) begin
				push_text(pick_char());
				push_text(pat_copy[i]);
			end else if (r != 1)
				push_text(pat_copy[i]);
		end
	endtask

	initial begin
		int       phase_end;
		logic [6:0] len_pick;
		logic [6:0] k_pick;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_item(asmk_pkg::MODE_LOAD, 8'hFF, 6'd63);
		push_item(asmk_pkg::MODE_LOAD, 8'h00, 6'd0);
		push_text(8'h00);
		push_text(8'hFF);
		push_item(MODE_UNUSED, 8'hA5, 6'h2A);
		push_restart();
		push_text(8'hFF);
		push_item(asmk_pkg::MODE_LOAD, 8'hFF, 6'd0);
		push_text(8'hFF);
		settle();
		write_regs(7'd0, 7'd0);
		push_text(8'h55);
		push_text(8'hAA);
		settle();
		write_regs(7'd127, 7'd64);
		load_pattern(1'b1);
		push_restart();
		copy_pattern();
		push_text(8'h00);
		settle();
		write_regs(7'd64, 7'd127);
		push_text(8'hFF);
		push_text(pat_copy[0]);
		settle();
		write_regs(7'd1, 7'd0);
		push_text(pat_copy[0]);
		push_text(8'h80);
		push_item(asmk_pkg::MODE_LOAD, 8'h00, 6'd5);
		push_text(8'h00);

		while (sent < ITEM_GOAL) begin
			settle();
			if (sent >= 2 * ITEM_GOAL / 3) begin
				send_idle = 0;
				recv_idle = 0;
			end else if (sent >= ITEM_GOAL / 3) begin
				send_idle = 45;
				recv_idle = 30;
			end
			case ($urandom_range(9))
				0: len_pick = 7'd0;
				1: len_pick = 7'd64;
				2: len_pick = 7'($urandom_range(65, 127));
				3: len_pick = 7'd1;
				default: len_pick = 7'($urandom_range(2, 12));
			endcase
			case ($urandom_range(5))
				0: k_pick = 7'd0;
				1: k_pick = 7'd127;
				2: k_pick = 7'd64;
				default: k_pick = 7'($urandom_range(0, 3));
			endcase
			write_regs(len_pick, k_pick);
			wide_alpha = ($urandom_range(4) == 0);
			load_pattern($urandom_range(3) != 0);
			if ($urandom_range(4) != 0)
				push_restart();
			phase_end = (sent + PHASE_ITEMS > ITEM_GOAL) ? ITEM_GOAL : sent + PHASE_ITEMS;
			while (sent < phase_end) begin
				case ($urandom_range(19))
					0: push_restart();
					1: push_item(asmk_pkg::MODE_LOAD, 8'($urandom), 6'($urandom));
					2: push_item(MODE_UNUSED, 8'($urandom), 6'($urandom));
					3, 4, 5, 6, 7, 8, 9, 10: copy_pattern();
					default: push_text(pick_char());
				endcase
			end
		end

		settle();
		$display("covered %0d items under %0d register settings", sent, settings_used);
		$display("%0d distance results checked, %0d of them reported as matches",
			checked, match_total);
		if (mismatches == 0 && outstanding == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
